@@ rtl/core/c32pd_pkg.sv @@
package c32pd_pkg;

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int COUNT_W = 33;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam int HDR_BYTES = 8;
    localparam int TRAILER_BYTES = 4;

    localparam logic REG_SYNC_FIRST = 1'b0;
    localparam logic REG_SYNC_SECOND = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_SYNC = 2'd1;
    localparam logic [1:0] STATUS_CRC = 2'd2;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_byte;
        logic [31:0] payload_offset;
        logic [1:0]  frame_status;
        logic [7:0]  command_kind;
        logic [7:0]  command_code;
        logic [31:0] length_seen;
        logic        packet_mode;
    } out_item_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0] data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ rtl/core/c32pd_in_if.sv @@
interface c32pd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/c32pd_out_if.sv @@
interface c32pd_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [31:0] payload_offset;
    logic [1:0]  frame_status;
    logic [7:0]  command_kind;
    logic [7:0]  command_code;
    logic [31:0] length_seen;
    logic        packet_mode;

    modport source (
        output valid, output item_kind, output payload_byte, output payload_offset,
        output frame_status, output command_kind, output command_code,
        output length_seen, output packet_mode, input ready
    );
    modport sink (
        input valid, input item_kind, input payload_byte, input payload_offset,
        input frame_status, input command_kind, input command_code,
        input length_seen, input packet_mode, output ready
    );
endinterface

@@ rtl/core/crc32_packet_deframer.sv @@
// Length-prefixed frame receiver: takes one byte per transfer on rx_chan and
// sustains one byte per clock cycle while the skid register is empty, since
// the eight-bit CRC-32 update and the frame bookkeeping complete in the cycle
// the byte is accepted. Payload bytes are registered before leaving on tx_chan,
// and the last CRC byte produces an end item carrying the frame status (ok,
// sync mismatch, CRC mismatch). A two-entry output buffer (result register
// plus skid register) keeps rx_chan ready while one result waits on tx_chan.
// Registers sync_first and sync_second sit at byte addresses 0 and 4 of the
// APB port and should be written only while no frame is in progress.
module crc32_packet_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [c32pd_pkg::ADDR_W-1:0]  paddr,
    input  logic [c32pd_pkg::DATA_W-1:0]  pwdata,
    output logic [c32pd_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    c32pd_in_if.sink                      rx_chan,
    c32pd_out_if.source                   tx_chan
);
    import c32pd_pkg::*;

    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic       reg_index;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [31:0]        crc_running_reg, crc_running_next;
    logic [31:0]        crc_received_reg, crc_received_next;
    logic [7:0]         header_kind_reg, header_kind_next;
    logic [7:0]         header_code_reg, header_code_next;
    logic [31:0]        header_length_reg, header_length_next;
    logic               sync_good_reg, sync_good_next;
    logic               mode_flag_reg, mode_flag_next;

    out_item_t out_reg;
    out_item_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;

    out_item_t          result;
    logic               has_result;
    logic               accept;
    logic               out_drain;
    logic [7:0]         rx_b;
    logic [COUNT_W-1:0] pay_end;
    logic [COUNT_W-1:0] pay_pos;
    logic [COUNT_W-1:0] crc_idx;
    logic [31:0]        crc_step;

    assign pready = 1'b1;
    assign reg_index = paddr[2];
    assign prdata = (reg_index == REG_SYNC_SECOND) ? {24'd0, sync_second_reg}
                                                   : {24'd0, sync_first_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg <= 8'd0;
            sync_second_reg <= 8'd0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (reg_index == REG_SYNC_FIRST)
            begin
                sync_first_reg <= pwdata[7:0];
            end
            else
            begin
                sync_second_reg <= pwdata[7:0];
            end
        end
    end

    assign rx_chan.ready = !skid_valid_reg;
    assign accept = rx_chan.valid && rx_chan.ready;
    assign out_drain = out_valid_reg && tx_chan.ready;
    assign rx_b = rx_chan.rx_byte;

    assign pay_end = COUNT_W'(HDR_BYTES) + {1'b0, header_length_reg};
    assign pay_pos = byte_count_reg - COUNT_W'(HDR_BYTES);
    assign crc_idx = byte_count_reg - pay_end;
    assign crc_step = crc32_byte(crc_running_reg, rx_b);

    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_running_next = crc_running_reg;
        crc_received_next = crc_received_reg;
        header_kind_next = header_kind_reg;
        header_code_next = header_code_reg;
        header_length_next = header_length_reg;
        sync_good_next = sync_good_reg;
        mode_flag_next = mode_flag_reg;
        has_result = 1'b0;

        result.item_kind = KIND_PAYLOAD;
        result.payload_byte = 8'd0;
        result.payload_offset = 32'd0;
        result.frame_status = STATUS_OK;
        result.command_kind = header_kind_reg;
        result.command_code = header_code_reg;
        result.length_seen = header_length_reg;
        result.packet_mode = 1'b0;

        if (accept)
        begin
            if (byte_count_reg == '0 && !mode_flag_reg && rx_b == sync_first_reg)
            begin
                mode_flag_next = 1'b1;
            end

            if (byte_count_reg < COUNT_W'(HDR_BYTES))
            begin
                crc_running_next = crc_step;
                byte_count_next = byte_count_reg + COUNT_W'(1);
                case (byte_count_reg[2:0])
                    3'd0:
                    begin
                        if (rx_b != sync_first_reg)
                        begin
                            sync_good_next = 1'b0;
                        end
                    end
                    3'd1:
                    begin
                        if (rx_b != sync_second_reg)
                        begin
                            sync_good_next = 1'b0;
                        end
                    end
                    3'd2: header_kind_next = rx_b;
                    3'd3: header_code_next = rx_b;
                    3'd4: header_length_next[7:0] = rx_b;
                    3'd5: header_length_next[15:8] = rx_b;
                    3'd6: header_length_next[23:16] = rx_b;
                    3'd7: header_length_next[31:24] = rx_b;
                    default: header_kind_next = header_kind_reg;
                endcase
            end
            else if (byte_count_reg < pay_end)
            begin
                crc_running_next = crc_step;
                byte_count_next = byte_count_reg + COUNT_W'(1);
                has_result = 1'b1;
                result.payload_byte = rx_b;
                result.payload_offset = pay_pos[31:0];
                result.packet_mode = mode_flag_next;
            end
            else
            begin
                crc_received_next = {rx_b, crc_received_reg[31:8]};
                if (crc_idx >= COUNT_W'(TRAILER_BYTES - 1))
                begin
                    has_result = 1'b1;
                    result.item_kind = KIND_END;
                    if (!sync_good_reg)
                    begin
                        result.frame_status = STATUS_SYNC;
                    end
                    else if ((crc_running_reg ^ CRC_INIT) != crc_received_next)
                    begin
                        result.frame_status = STATUS_CRC;
                    end
                    byte_count_next = '0;
                    crc_running_next = CRC_INIT;
                    crc_received_next = 32'd0;
                    sync_good_next = 1'b1;
                    mode_flag_next = 1'b0;
                end
                else
                begin
                    byte_count_next = byte_count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_running_reg <= CRC_INIT;
            crc_received_reg <= 32'd0;
            header_kind_reg <= 8'd0;
            header_code_reg <= 8'd0;
            header_length_reg <= 32'd0;
            sync_good_reg <= 1'b1;
            mode_flag_reg <= 1'b0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            crc_running_reg <= crc_running_next;
            crc_received_reg <= crc_received_next;
            header_kind_reg <= header_kind_next;
            header_code_reg <= header_code_next;
            header_length_reg <= header_length_next;
            sync_good_reg <= sync_good_next;
            mode_flag_reg <= mode_flag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_drain)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (has_result)
        begin
            if (out_valid_reg && !tx_chan.ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_drain)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_drain)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (has_result)
        begin
            if (out_valid_reg && !tx_chan.ready)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign tx_chan.valid = out_valid_reg;
    assign tx_chan.item_kind = out_reg.item_kind;
    assign tx_chan.payload_byte = out_reg.payload_byte;
    assign tx_chan.payload_offset = out_reg.payload_offset;
    assign tx_chan.frame_status = out_reg.frame_status;
    assign tx_chan.command_kind = out_reg.command_kind;
    assign tx_chan.command_code = out_reg.command_code;
    assign tx_chan.length_seen = out_reg.length_seen;
    assign tx_chan.packet_mode = out_reg.packet_mode;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_end_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (has_result && result.item_kind == KIND_END) |=>
            (byte_count_reg == '0 && !mode_flag_reg && sync_good_reg))
        else $error("frame state not cleared after end of frame");

    a_sync_bad_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !sync_good_reg |-> byte_count_reg != '0)
        else $error("sync failure flagged outside a frame");

    a_end_mode_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.item_kind == KIND_END) |-> !out_reg.packet_mode)
        else $error("end item shows packet mode");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.frame_status == STATUS_OK ||
                           out_reg.frame_status == STATUS_SYNC ||
                           out_reg.frame_status == STATUS_CRC))
        else $error("undefined frame status code");

endmodule
